// File: sv/qtg_pkg.sv
// Shared constants and codes for the quintic trajectory generator.
package qtg_pkg;

    // Number of joint entries held in each coordinate store
    localparam int JOINTS = 8;
    localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int JCNT_W = $clog2(JOINTS + 1);
    // Joints that one tick may emit
    localparam int JCAP   = (JOINTS < 8) ? JOINTS : 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP = 1'b0,
        REG_JOINTS    = 1'b1
    } t_reg_idx;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_COMMIT = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_SAMPLE   = 2'd0,
        ST_IDLE     = 2'd1,
        ST_ACCEPTED = 2'd2,
        ST_REJECTED = 2'd3
    } t_status;

endpackage

// File: sv/qtg_in_if.sv
// Input channel: command transactions into the trajectory generator.
interface qtg_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [2:0]         joint_index;
    logic signed [31:0] joint_value;
    logic [31:0]        waypoint_time;

    modport source (output valid, cmd, joint_index, joint_value, waypoint_time, input ready);
    modport sink   (input valid, cmd, joint_index, joint_value, waypoint_time, output ready);
endinterface

// File: sv/qtg_out_if.sv
// Output channel: result transactions from the trajectory generator.
interface qtg_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [2:0]         joint_index_res;
    logic signed [31:0] position;
    logic signed [47:0] velocity;
    logic signed [47:0] acceleration;
    logic [31:0]        sample_time;
    logic               last;

    modport source (output valid, status, joint_index_res, position, velocity, acceleration,
                    sample_time, last, input ready);
    modport sink   (input valid, status, joint_index_res, position, velocity, acceleration,
                    sample_time, last, output ready);
endinterface

// File: sv/qtg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module qtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: sv/quintic_trajectory_generator.sv
// Rest-to-rest quintic trajectory generator, top level.
//
// Usage: the input channel carries command transactions. A load writes one
// joint coordinate of the next waypoint and produces nothing. A commit
// closes the waypoint: it returns one result (accepted or rejected). On the
// second and later accepted waypoints a segment opens from the previous one.
// A tick returns one sample per joint in use (position, velocity,
// acceleration, sample time), last set on the final joint, or one idle
// result when the segment has no steps left.
// Sequence: a commit copies the coordinate stores joint by joint, then runs
// the step-count division once a segment is open. A tick runs shared setup
// after acceptance (the sample-time multiply, one 64-step divide for u and
// seven multiplies), then per joint the shared 1-bit-per-cycle divider runs
// three times. One transaction is worked on at a time; the input is ready
// only while the block is idle.
// Reset clears the segment state, time_step to 1 and joints_in_use to 8;
// coordinate stores hold nothing until loaded. A stalled receiver holds the
// result register and the sequence waits; nothing is dropped.
module quintic_trajectory_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    qtg_in_if.sink                           i_in,
    qtg_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [qtg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qtg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import qtg_pkg::*;

    localparam logic [31:0] ONE31    = 32'h8000_0000;
    localparam logic [31:0] HALF31   = 32'h4000_0000;
    localparam logic [6:0]  DIV_STEPS = 7'd64;

    typedef enum logic [4:0] {
        S_IDLE, S_OUT, S_SWEEP, S_CDIV_GO, S_CDIV_WT,
        S_TMUL, S_UDIV_GO, S_UDIV_WT, S_U2, S_U3, S_U4, S_U5, S_W, S_G, S_H,
        S_JRD, S_JD, S_JP, S_JV, S_VDIV_GO, S_VDIV_WT, S_JA,
        S_A1_GO, S_A1_WT, S_A2_GO, S_A2_WT, S_JOUT
    } t_state;

    t_state r_state;

    // Configuration and segment state
    logic [15:0]       r_time_step;
    logic [3:0]        r_joints;
    logic [31:0]       r_prev, r_dur, r_step_cnt, r_steps_total, r_wtime;
    logic              r_have;
    logic [JCNT_W-1:0] r_j;

    // Shared tick terms
    logic [31:0] r_t, r_u, r_u2, r_u3, r_u4, r_u5, r_w, r_g, r_h, r_cm, r_s;
    logic        r_cneg;

    // Per-joint terms
    logic               r_neg;
    logic [32:0]        r_m;
    logic [31:0]        r_p0;
    logic signed [31:0] r_pos;
    logic signed [47:0] r_vel;
    logic [63:0]        r_num;

    // Result register
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [2:0]         r_out_j;
    logic signed [31:0] r_out_pos;
    logic signed [47:0] r_out_vel, r_out_acc;
    logic [31:0]        r_out_time;
    logic               r_out_last;

    // Divider
    logic [31:0] r_dv_rem, r_dv_den;
    logic [63:0] r_dv_quo;
    logic [6:0]  r_dv_cnt;
    logic        dv_start, dv_done;
    logic [63:0] dv_num;
    logic [31:0] dv_den;

    // Multiplier
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] prod;

    // RAM ports
    logic              pend_we, seg_we;
    logic [JIDX_W-1:0] pend_waddr, seg_waddr, j_addr;
    logic [31:0]       pend_rdata, start_rdata, end_rdata;

    logic              in_acc, jidx_ok, out_fire;
    logic [15:0]       step_eff;
    logic [3:0]        jn;
    logic [JCNT_W-1:0] n_use;
    logic              j_last;

    // Effective config
    assign step_eff = (r_time_step == 16'd0) ? 16'd1 : r_time_step;
    assign jn       = (r_joints == 4'd0) ? 4'd1 :
                      ((r_joints > 4'(JCAP)) ? 4'(JCAP) : r_joints);
    assign n_use    = JCNT_W'(jn);
    assign j_last   = (r_j == n_use - 1'b1);

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign jidx_ok  = ({29'd0, i_in.joint_index} < 32'(JOINTS));
    assign i_in.ready = (r_state == S_IDLE);

    // Coordinate stores
    assign j_addr     = r_j[JIDX_W-1:0];
    assign pend_we    = in_acc && (i_in.cmd == CMD_LOAD) && jidx_ok;
    assign pend_waddr = JIDX_W'(i_in.joint_index);
    assign seg_we     = (r_state == S_SWEEP) && (r_j != '0);
    assign seg_waddr  = JIDX_W'(r_j - 1'b1);

    qtg_ram #(.WIDTH(32), .DEPTH(JOINTS)) u_pend (
        .i_clk(i_clk), .i_we(pend_we), .i_waddr(pend_waddr),
        .i_wdata(i_in.joint_value), .i_raddr(j_addr), .o_rdata(pend_rdata));

    qtg_ram #(.WIDTH(32), .DEPTH(JOINTS)) u_start (
        .i_clk(i_clk), .i_we(seg_we), .i_waddr(seg_waddr),
        .i_wdata(end_rdata), .i_raddr(j_addr), .o_rdata(start_rdata));

    qtg_ram #(.WIDTH(32), .DEPTH(JOINTS)) u_end (
        .i_clk(i_clk), .i_we(seg_we), .i_waddr(seg_waddr),
        .i_wdata(pend_rdata), .i_raddr(j_addr), .o_rdata(end_rdata));

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_TMUL: begin mul_a = {1'b0, r_step_cnt}; mul_b = {16'd0, step_eff}; end
            S_U2:   begin mul_a = {1'b0, r_u};  mul_b = r_u; end
            S_U3:   begin mul_a = {1'b0, r_u2}; mul_b = r_u; end
            S_U4:   begin mul_a = {1'b0, r_u3}; mul_b = r_u; end
            S_U5:   begin mul_a = {1'b0, r_u4}; mul_b = r_u; end
            S_W:    begin mul_a = {1'b0, r_u};  mul_b = ONE31 - r_u; end
            S_G:    begin mul_a = {1'b0, r_w};  mul_b = r_w; end
            S_H:    begin mul_a = {1'b0, r_w};  mul_b = r_cm; end
            S_JP:   begin mul_a = r_m; mul_b = r_s; end
            S_JV:   begin mul_a = r_m; mul_b = r_g; end
            S_JA:   begin mul_a = r_m; mul_b = r_h; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod = 65'(mul_a) * 65'(mul_b);

    // Divider operand select
    always_comb begin
        dv_start = 1'b0;
        dv_num   = r_num;
        dv_den   = r_dur;
        case (r_state)
            S_CDIV_GO: begin dv_start = 1'b1; dv_num = 64'(r_dur); dv_den = 32'(step_eff); end
            S_UDIV_GO: begin dv_start = 1'b1; dv_num = {1'b0, r_t, 31'd0}; end
            S_VDIV_GO: dv_start = 1'b1;
            S_A1_GO:   dv_start = 1'b1;
            S_A2_GO:   dv_start = 1'b1;
            default:   dv_start = 1'b0;
        endcase
    end

    // Restoring divider, one quotient bit per cycle
    logic [32:0] dv_sh, dv_diff;
    logic        dv_ge;
    assign dv_sh   = {r_dv_rem, r_dv_quo[63]};
    assign dv_diff = dv_sh - {1'b0, r_dv_den};
    assign dv_ge   = (dv_sh >= {1'b0, r_dv_den});
    assign dv_done = (r_dv_cnt == 7'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt <= 7'd0;
        end else if (dv_start) begin
            r_dv_quo <= dv_num;
            r_dv_rem <= 32'd0;
            r_dv_den <= dv_den;
            r_dv_cnt <= DIV_STEPS;
        end else if (!dv_done) begin
            r_dv_rem <= dv_ge ? dv_diff[31:0] : dv_sh[31:0];
            r_dv_quo <= {r_dv_quo[62:0], dv_ge};
            r_dv_cnt <= r_dv_cnt - 7'd1;
        end
    end

    // Blend polynomial s = 10u^3 - 15u^4 + 6u^5, clamped to [0, 1]
    logic [36:0] s_plus, s_minus, s_diff;
    logic [31:0] s_val;
    assign s_plus  = 37'(r_u3) * 37'd10 + 37'(r_u5) * 37'd6;
    assign s_minus = 37'(r_u4) * 37'd15;
    assign s_diff  = s_plus - s_minus;
    assign s_val   = (s_plus <= s_minus) ? 32'd0 :
                     ((s_diff > 37'(ONE31)) ? ONE31 : s_diff[31:0]);

    // Slope term 2^31 - 2U, split into magnitude and sign
    logic [32:0] two_u;
    logic        c_neg;
    logic [32:0] c_mag;
    assign two_u = {r_u, 1'b0};
    assign c_neg = (r_u > HALF31);
    assign c_mag = c_neg ? (two_u - {1'b0, ONE31}) : ({1'b0, ONE31} - two_u);

    // Joint difference and position
    logic signed [32:0] d_val;
    logic signed [34:0] pos_sum;
    logic signed [31:0] pos_sat;
    assign d_val   = {end_rdata[31], end_rdata} - {start_rdata[31], start_rdata};
    assign pos_sum = r_neg ? ($signed({{3{r_p0[31]}}, r_p0}) - $signed({1'b0, prod[64:31]}))
                           : ($signed({{3{r_p0[31]}}, r_p0}) + $signed({1'b0, prod[64:31]}));
    assign pos_sat = (pos_sum > 35'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                     ((pos_sum < -35'sh0_8000_0000) ? -32'sh8000_0000 : pos_sum[31:0]);

    // Saturate a quotient magnitude with sign into 48 bits
    function automatic logic signed [47:0] sat48(input logic [63:0] mag, input logic neg);
        logic [63:0] lim;
        logic [47:0] m;
        lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
        m   = (mag > lim) ? lim[47:0] : mag[47:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    logic [64:0] t_prod;
    assign t_prod = prod;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_time_step   <= 16'd1;
            r_joints      <= 4'd8;
            r_prev        <= 32'd0;
            r_dur         <= 32'd0;
            r_step_cnt    <= 32'd0;
            r_steps_total <= 32'd0;
            r_have        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_j           <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_TIME_STEP: r_time_step <= i_cfg_data;
                    REG_JOINTS:    r_joints    <= i_cfg_data[3:0];
                    default:       ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_out_j    <= 3'd0;
                    r_out_pos  <= '0;
                    r_out_vel  <= '0;
                    r_out_acc  <= '0;
                    r_out_time <= 32'd0;
                    r_out_last <= 1'b1;
                    if (in_acc) begin
                        case (t_cmd'(i_in.cmd))
                            CMD_COMMIT: begin
                                if (r_have && (i_in.waypoint_time <= r_prev)) begin
                                    r_out_status <= ST_REJECTED;
                                    r_out_valid  <= 1'b1;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_wtime <= i_in.waypoint_time;
                                    r_j     <= '0;
                                    r_state <= S_SWEEP;
                                end
                            end
                            CMD_TICK: begin
                                if ((r_step_cnt >= r_steps_total) || (r_dur == 32'd0)) begin
                                    r_out_status <= ST_IDLE;
                                    r_out_valid  <= 1'b1;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_step_cnt <= r_step_cnt + 32'd1;
                                    r_state    <= S_TMUL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                // Copy end to start and pending to end, one joint per cycle
                S_SWEEP: begin
                    if (r_j == JCNT_W'(JOINTS)) begin
                        r_step_cnt   <= 32'd0;
                        r_prev       <= r_wtime;
                        r_have       <= 1'b1;
                        r_out_status <= ST_ACCEPTED;
                        if (r_have) begin
                            r_dur   <= r_wtime - r_prev;
                            r_state <= S_CDIV_GO;
                        end else begin
                            r_dur         <= 32'd0;
                            r_steps_total <= 32'd0;
                            r_out_valid   <= 1'b1;
                            r_state       <= S_OUT;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_CDIV_GO: r_state <= S_CDIV_WT;
                S_CDIV_WT: begin
                    if (dv_done) begin
                        r_steps_total <= r_dv_quo[31:0];
                        r_out_valid   <= 1'b1;
                        r_state       <= S_OUT;
                    end
                end
                // Sample time, capped at the segment length
                S_TMUL: begin
                    r_t     <= (t_prod > 65'(r_dur)) ? r_dur : t_prod[31:0];
                    r_state <= S_UDIV_GO;
                end
                S_UDIV_GO: r_state <= S_UDIV_WT;
                S_UDIV_WT: begin
                    if (dv_done) begin
                        r_u     <= r_dv_quo[31:0];
                        r_state <= S_U2;
                    end
                end
                S_U2: begin r_u2 <= prod[62:31]; r_state <= S_U3; end
                S_U3: begin r_u3 <= prod[62:31]; r_state <= S_U4; end
                S_U4: begin r_u4 <= prod[62:31]; r_state <= S_U5; end
                S_U5: begin r_u5 <= prod[62:31]; r_state <= S_W; end
                S_W: begin
                    r_w    <= prod[62:31];
                    r_cm   <= c_mag[31:0];
                    r_cneg <= c_neg;
                    r_state <= S_G;
                end
                S_G: begin
                    r_g     <= prod[62:31];
                    r_s     <= s_val;
                    r_state <= S_H;
                end
                S_H: begin
                    r_h     <= prod[62:31];
                    r_j     <= '0;
                    r_state <= S_JRD;
                end
                // Per-joint work
                S_JRD: r_state <= S_JD;
                S_JD: begin
                    r_p0    <= start_rdata;
                    r_neg   <= d_val[32];
                    r_m     <= d_val[32] ? 33'(-d_val) : 33'(d_val);
                    r_state <= S_JP;
                end
                S_JP: begin
                    r_pos   <= pos_sat;
                    r_state <= S_JV;
                end
                S_JV: begin
                    r_num   <= 64'(prod[64:15]) * 64'd30;
                    r_state <= S_VDIV_GO;
                end
                S_VDIV_GO: r_state <= S_VDIV_WT;
                S_VDIV_WT: begin
                    if (dv_done) begin
                        r_vel   <= sat48(r_dv_quo, r_neg);
                        r_state <= S_JA;
                    end
                end
                S_JA: begin
                    r_num   <= 64'(prod[64:15]) * 64'd60;
                    r_state <= S_A1_GO;
                end
                S_A1_GO: r_state <= S_A1_WT;
                S_A1_WT: begin
                    if (dv_done) begin
                        r_num   <= r_dv_quo;
                        r_state <= S_A2_GO;
                    end
                end
                S_A2_GO: r_state <= S_A2_WT;
                S_A2_WT: begin
                    if (dv_done) begin
                        r_out_status <= ST_SAMPLE;
                        r_out_j      <= 3'(r_j);
                        r_out_pos    <= r_pos;
                        r_out_vel    <= r_vel;
                        r_out_acc    <= sat48(r_dv_quo, r_neg != r_cneg);
                        r_out_time   <= r_prev - r_dur + r_t;
                        r_out_last   <= j_last;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_JOUT;
                    end
                end
                S_JOUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_JRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output channel
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.joint_index_res = r_out_j;
    assign o_out.position        = r_out_pos;
    assign o_out.velocity        = r_out_vel;
    assign o_out.acceleration    = r_out_acc;
    assign o_out.sample_time     = r_out_time;
    assign o_out.last            = r_out_last;

    // Checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a result is pending");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_start |-> dv_done)
        else $error("divider restarted while busy");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step_cnt <= r_steps_total)
        else $error("step count beyond segment");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && (o_out.status != ST_SAMPLE)) |-> o_out.last)
        else $error("non-sample result without last");

    a_no_dur_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_dur == 32'd0))
        else $error("segment open before first waypoint");

endmodule
